>>> rtl/rws_pkg.sv
package rws_pkg;

  localparam int ID_W     = 16;
  localparam int WEIGHT_W = 16;
  localparam int FRAC_W   = 16;

  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_SELECT = 1'b1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_INS_WR  = 3'd3;
  localparam logic [2:0] S_MUL     = 3'd4;
  localparam logic [2:0] S_SEL_RD  = 3'd5;
  localparam logic [2:0] S_SEL_CMP = 3'd6;
  localparam logic [2:0] S_FIN     = 3'd7;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [WEIGHT_W-1:0] weight;
  } entry_t;

endpackage

>>> rtl/roulette_wheel_selector_core.sv
// Roulette wheel selector.
// Input channel (in_valid / in_ready) carries one request: mode selects an
// add (element_id, weight) or a select (random_fraction, Q0.16). Output
// channel (out_valid / out_ready) returns exactly one result per request:
// selected_id, found, add_dropped and table_empty.
// The table lives in one synchronous memory of ENTRIES {id, weight} words,
// one read port and one write port, registered read data. An add walks
// the table from the top, moving each heavier entry up by one slot (below
// the top entry, an equal one moves as well); for each moved entry it
// reads, then compares and writes back. A select first forms the product
// random_fraction * total, then scans cumulative weights from the bottom,
// reading and then comparing each visited entry. A full table drops an
// add, and an empty table answers a select without a scan.
// One request is in work at a time; in_ready is high only while idle.
// When the receiver stalls, the finished result waits in the output
// register; the next request is accepted, but its result is held back until
// the previous one is taken. Reset empties the table (count and total to
// zero) and drops any result in flight; memory contents are left as is.
module roulette_wheel_selector_core
  import rws_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  logic [ID_W-1:0]     element_id,
  input  logic [WEIGHT_W-1:0] weight,
  input  logic [FRAC_W-1:0]   random_fraction,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ID_W-1:0]     selected_id,
  output logic                found,
  output logic                add_dropped,
  output logic                table_empty
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  // total never exceeds ENTRIES * 65535
  localparam int TOT_W  = WEIGHT_W + IDX_W;
  localparam int PROD_W = TOT_W + FRAC_W;

  // table storage
  entry_t mem [ENTRIES];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  logic [2:0]          state;
  logic [CNT_W-1:0]    count;
  logic [TOT_W-1:0]    total;
  logic [CNT_W-1:0]    k;
  logic                first;
  logic [TOT_W-1:0]    cum;
  logic [PROD_W-1:0]   target;
  logic [ID_W-1:0]     req_id;
  logic [WEIGHT_W-1:0] req_weight;
  logic [FRAC_W-1:0]   req_frac;

  // pending result, waiting for the output register
  logic [ID_W-1:0]     res_id;
  logic                res_found;
  logic                res_dropped;
  logic                res_empty;

  logic                in_fire;
  logic                shift;
  logic [TOT_W-1:0]    cum_sum;
  logic                hit;
  logic [CNT_W-1:0]    k_dec;
  logic [CNT_W-1:0]    k_inc;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign k_dec    = k - CNT_W'(1);
  assign k_inc    = k + CNT_W'(1);

  // the top entry moves only if strictly heavier: equal weight appends
  assign shift   = first ? (rdata.weight > req_weight) : (rdata.weight >= req_weight);
  assign cum_sum = cum + TOT_W'(rdata.weight);
  assign hit     = ({cum_sum, {FRAC_W{1'b0}}} >= target) || (k_inc == count);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = k[IDX_W-1:0];
    mem_wdata = '{id: req_id, weight: req_weight};
    mem_raddr = k[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        // first add into an empty table goes straight to slot zero
        mem_waddr = '0;
        mem_wdata = '{id: element_id, weight: weight};
        mem_we    = in_fire && (mode == MODE_ADD) && (count == '0);
      end
      S_INS_RD: begin
        mem_raddr = k_dec[IDX_W-1:0];
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (shift) begin
          mem_wdata = rdata;
        end
      end
      S_INS_WR: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      // S_FIN reloads the output register on its own
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            req_id      <= element_id;
            req_weight  <= weight;
            req_frac    <= random_fraction;
            res_id      <= '0;
            res_found   <= 1'b0;
            res_dropped <= 1'b0;
            res_empty   <= (count == '0);
            if (mode == MODE_ADD) begin
              if (count == CNT_W'(ENTRIES)) begin
                res_dropped <= 1'b1;
                state       <= S_FIN;
              end else if (count == '0) begin
                count     <= CNT_W'(1);
                total     <= TOT_W'(weight);
                res_empty <= 1'b0;
                state     <= S_FIN;
              end else begin
                k     <= count;
                first <= 1'b1;
                state <= S_INS_RD;
              end
            end else begin
              state <= (count == '0) ? S_FIN : S_MUL;
            end
          end
        end
        S_INS_RD: begin
          state <= S_INS_CMP;
        end
        S_INS_CMP: begin
          first <= 1'b0;
          if (shift) begin
            // entry moved up; continue downward or drop new one into slot zero
            k     <= k_dec;
            state <= (k == CNT_W'(1)) ? S_INS_WR : S_INS_RD;
          end else begin
            count     <= count + CNT_W'(1);
            total     <= total + TOT_W'(req_weight);
            res_empty <= 1'b0;
            state     <= S_FIN;
          end
        end
        S_INS_WR: begin
          count     <= count + CNT_W'(1);
          total     <= total + TOT_W'(req_weight);
          res_empty <= 1'b0;
          state     <= S_FIN;
        end
        S_MUL: begin
          target <= PROD_W'(req_frac) * PROD_W'(total);
          cum    <= '0;
          k      <= '0;
          state  <= S_SEL_RD;
        end
        S_SEL_RD: begin
          state <= S_SEL_CMP;
        end
        S_SEL_CMP: begin
          if (hit) begin
            res_id    <= rdata.id;
            res_found <= 1'b1;
            state     <= S_FIN;
          end else begin
            cum   <= cum_sum;
            k     <= k_inc;
            state <= S_SEL_RD;
          end
        end
        S_FIN: begin
          // hold the result until the output register is free
          if (!out_valid || out_ready) begin
            selected_id <= res_id;
            found       <= res_found;
            add_dropped <= res_dropped;
            table_empty <= res_empty;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
